/* rtl/rtc_pkg.sv */
// Shared types and constants for the rigid transform composer.
`default_nettype none
package rtc_pkg;

	// Quaternion parts travel as 32-bit words on every port
	localparam int QUAT_W     = 32;
	localparam int QUAT_PARTS = 4;
	localparam int CFG_IDX_W  = 3;

	// Register map of the configuration channel
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_TX = 3'd0,
		REG_BASE_TY = 3'd1,
		REG_BASE_TZ = 3'd2,
		REG_BASE_QW = 3'd3,
		REG_BASE_QX = 3'd4,
		REG_BASE_QY = 3'd5,
		REG_BASE_QZ = 3'd6
	} cfg_reg_t;

	// Hamilton product: part k sums a[j] * b[j ^ k]; a set bit subtracts term j
	localparam logic [QUAT_PARTS-1:0][QUAT_PARTS-1:0] HAM_NEG =
		{4'b0100, 4'b0010, 4'b1000, 4'b1110};

endpackage
`default_nettype wire

/* rtl/rtc_front.sv */
// Front pipeline: clamp, translation rotation and Hamilton product up to its squared norm.
`default_nettype none
module rtc_front #(
	parameter int F = 30,
	parameter int T = 32
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        en,
	input  logic                                        in_vld,
	input  logic [2:0][T-1:0]                           v,
	input  logic [rtc_pkg::QUAT_PARTS-1:0][rtc_pkg::QUAT_W-1:0] iq,
	input  logic [2:0][T-1:0]                           bt,
	input  logic [rtc_pkg::QUAT_PARTS-1:0][rtc_pkg::QUAT_W-1:0] bq,
	output logic                                        out_vld,
	output logic [2*F+3:0]                              sum,
	output logic [rtc_pkg::QUAT_PARTS-1:0][F+1:0]       pm,
	output logic [rtc_pkg::QUAT_PARTS-1:0]              ps,
	output logic                                        zero,
	output logic [2:0][T-1:0]                           t
);
	import rtc_pkg::*;

	localparam int QCW = F + 2;
	localparam int PTW = QCW + T;
	localparam int CXW = T + 3;
	localparam int MTW = QCW + CXW;
	localparam int HPW = 2 * QCW;
	localparam int PMW = F + 2;
	localparam int SQW = 2 * PMW;
	localparam int SW  = 2 * F + 4;
	localparam int R2W = T + 3;
	localparam int RXW = T + 4;
	localparam logic signed [QUAT_W-1:0] QONE = QUAT_W'(64'd1 << F);
	localparam logic signed [RXW-1:0] TMAX = {{(RXW-T+1){1'b0}}, {(T-1){1'b1}}};
	localparam logic signed [RXW-1:0] TMIN = ~TMAX;

	function automatic logic signed [QCW-1:0] clampq(input logic [QUAT_W-1:0] raw);
		logic signed [QUAT_W-1:0] x;
		x = $signed(raw);
		if (x > QONE)
			x = QONE;
		else if (x < -QONE)
			x = -QONE;
		clampq = QCW'(x);
	endfunction

	function automatic logic signed [T:0] rnd_pt(input logic signed [PTW-1:0] x);
		logic [PTW-1:0] m;
		logic [PTW-1:0] s;
		m = x[PTW-1] ? PTW'(-x) : PTW'(x);
		s = (m + (PTW'(1) << (F-1))) >> F;
		rnd_pt = x[PTW-1] ? -$signed((T+1)'(s)) : $signed((T+1)'(s));
	endfunction

	function automatic logic signed [R2W-1:0] rnd_mt(input logic signed [MTW-1:0] x);
		logic [MTW-1:0] m;
		logic [MTW-1:0] s;
		m = x[MTW-1] ? MTW'(-x) : MTW'(x);
		s = (m + (MTW'(1) << (F-1))) >> F;
		rnd_mt = x[MTW-1] ? -$signed(R2W'(s)) : $signed(R2W'(s));
	endfunction

	function automatic logic [T-1:0] sat(input logic signed [RXW-1:0] x);
		if (x > TMAX)
			sat = TMAX[T-1:0];
		else if (x < TMIN)
			sat = TMIN[T-1:0];
		else
			sat = x[T-1:0];
	endfunction

	logic                        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [QCW-1:0]       a_s1 [QUAT_PARTS];
	logic signed [QCW-1:0]       b_s1 [QUAT_PARTS];
	logic signed [T-1:0]         v_s1 [3];
	logic signed [T-1:0]         bt_s1 [3];
	logic signed [PTW-1:0]       pt_n [6];
	logic signed [HPW-1:0]       hp_n [16];
	logic signed [PTW-1:0]       pt_s2 [6];
	logic signed [HPW-1:0]       hp_s2 [16];
	logic signed [QCW-1:0]       a_s2 [QUAT_PARTS];
	logic signed [T-1:0]         v_s2 [3];
	logic signed [T-1:0]         bt_s2 [3];
	logic signed [T:0]           r_n [6];
	logic signed [HPW-1:0]       hs_n [QUAT_PARTS];
	logic signed [CXW-1:0]       c_s3 [3];
	logic signed [HPW-1:0]       hs_s3 [QUAT_PARTS];
	logic signed [QCW-1:0]       a_s3 [QUAT_PARTS];
	logic signed [T-1:0]         v_s3 [3];
	logic signed [T-1:0]         bt_s3 [3];
	logic signed [MTW-1:0]       m_n [9];
	logic [PMW-1:0]              pm_n [QUAT_PARTS];
	logic signed [MTW-1:0]       m_s4 [9];
	logic [PMW-1:0]              pm_s4 [QUAT_PARTS];
	logic [QUAT_PARTS-1:0]       ps_s4;
	logic signed [T-1:0]         v_s4 [3];
	logic signed [T-1:0]         bt_s4 [3];
	logic signed [R2W-1:0]       rr_n [9];
	logic signed [RXW-1:0]       rx_n [3];
	logic [T-1:0]                t_s5 [3];
	logic [SQW-1:0]              sq_s5 [QUAT_PARTS];
	logic [PMW-1:0]              pm_s5 [QUAT_PARTS];
	logic [QUAT_PARTS-1:0]       ps_s5;
	logic [SQW+1:0]              sum_n;
	logic [SW-1:0]               sum_s6;
	logic [PMW-1:0]              pm_s6 [QUAT_PARTS];
	logic [QUAT_PARTS-1:0]       ps_s6;
	logic                        zero_s6;
	logic [T-1:0]                t_s6 [3];

	// Advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Stage 2 products: cross terms for u x v, and the sixteen Hamilton terms
	always_comb begin
		pt_n[0] = a_s1[2] * v_s1[2];
		pt_n[1] = a_s1[3] * v_s1[1];
		pt_n[2] = a_s1[3] * v_s1[0];
		pt_n[3] = a_s1[1] * v_s1[2];
		pt_n[4] = a_s1[1] * v_s1[1];
		pt_n[5] = a_s1[2] * v_s1[0];
		for (int k = 0; k < QUAT_PARTS; k++) begin
			for (int j = 0; j < QUAT_PARTS; j++) begin
				hp_n[4*k+j] = a_s1[j] * b_s1[j ^ k];
			end
		end
	end

	// Stage 3: round cross terms, double them, and sum the Hamilton terms
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			r_n[i] = rnd_pt(pt_s2[i]);
		end
		for (int k = 0; k < QUAT_PARTS; k++) begin
			hs_n[k] = '0;
			for (int j = 0; j < QUAT_PARTS; j++) begin
				if (HAM_NEG[k][j])
					hs_n[k] = hs_n[k] - hp_s2[4*k+j];
				else
					hs_n[k] = hs_n[k] + hp_s2[4*k+j];
			end
		end
	end

	// Stage 4 products: w*c plus u x c, and product parts rounded to F-1 fraction bits
	always_comb begin
		logic [HPW-1:0] mg;
		logic [HPW-1:0] rs;
		m_n[0] = a_s3[0] * c_s3[0];
		m_n[1] = a_s3[2] * c_s3[2];
		m_n[2] = a_s3[3] * c_s3[1];
		m_n[3] = a_s3[0] * c_s3[1];
		m_n[4] = a_s3[3] * c_s3[0];
		m_n[5] = a_s3[1] * c_s3[2];
		m_n[6] = a_s3[0] * c_s3[2];
		m_n[7] = a_s3[1] * c_s3[1];
		m_n[8] = a_s3[2] * c_s3[0];
		for (int k = 0; k < QUAT_PARTS; k++) begin
			mg = hs_s3[k][HPW-1] ? HPW'(-hs_s3[k]) : HPW'(hs_s3[k]);
			rs = (mg + (HPW'(1) << F)) >> (F + 1);
			pm_n[k] = rs[PMW-1:0];
		end
	end

	// Stage 5: finish the rotated translation and add the held offset
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			rr_n[i] = rnd_mt(m_s4[i]);
		end
		rx_n[0] = RXW'(v_s4[0]) + RXW'(rr_n[0]) + RXW'(rr_n[1]) - RXW'(rr_n[2])
			+ RXW'(bt_s4[0]);
		rx_n[1] = RXW'(v_s4[1]) + RXW'(rr_n[3]) + RXW'(rr_n[4]) - RXW'(rr_n[5])
			+ RXW'(bt_s4[1]);
		rx_n[2] = RXW'(v_s4[2]) + RXW'(rr_n[6]) + RXW'(rr_n[7]) - RXW'(rr_n[8])
			+ RXW'(bt_s4[2]);
	end

	// Stage 6: sum of squares of the product parts
	assign sum_n = (SQW+2)'(sq_s5[0]) + (SQW+2)'(sq_s5[1])
		+ (SQW+2)'(sq_s5[2]) + (SQW+2)'(sq_s5[3]);

	// Pipeline data registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QUAT_PARTS; k++) begin
				a_s1[k]  <= clampq(bq[k]);
				b_s1[k]  <= clampq(iq[k]);
				a_s2[k]  <= a_s1[k];
				a_s3[k]  <= a_s2[k];
				hs_s3[k] <= hs_n[k];
				pm_s4[k] <= pm_n[k];
				ps_s4[k] <= hs_s3[k][HPW-1];
				sq_s5[k] <= pm_s4[k] * pm_s4[k];
				pm_s5[k] <= pm_s4[k];
				pm_s6[k] <= pm_s5[k];
			end
			ps_s5 <= ps_s4;
			ps_s6 <= ps_s5;
			for (int i = 0; i < 3; i++) begin
				v_s1[i]  <= $signed(v[i]);
				bt_s1[i] <= $signed(bt[i]);
				v_s2[i]  <= v_s1[i];
				bt_s2[i] <= bt_s1[i];
				v_s3[i]  <= v_s2[i];
				bt_s3[i] <= bt_s2[i];
				v_s4[i]  <= v_s3[i];
				bt_s4[i] <= bt_s3[i];
				t_s5[i]  <= sat(rx_n[i]);
				t_s6[i]  <= t_s5[i];
			end
			for (int i = 0; i < 6; i++) begin
				pt_s2[i] <= pt_n[i];
			end
			for (int i = 0; i < 16; i++) begin
				hp_s2[i] <= hp_n[i];
			end
			c_s3[0] <= (CXW'(r_n[0]) - CXW'(r_n[1])) <<< 1;
			c_s3[1] <= (CXW'(r_n[2]) - CXW'(r_n[3])) <<< 1;
			c_s3[2] <= (CXW'(r_n[4]) - CXW'(r_n[5])) <<< 1;
			for (int i = 0; i < 9; i++) begin
				m_s4[i] <= m_n[i];
			end
			sum_s6  <= sum_n[SW-1:0];
			zero_s6 <= (pm_s5[0] == '0) && (pm_s5[1] == '0)
				&& (pm_s5[2] == '0) && (pm_s5[3] == '0);
		end
	end

	assign out_vld = vld_s6;
	assign sum     = sum_s6;
	assign ps      = ps_s6;
	assign zero    = zero_s6;
	always_comb begin
		for (int k = 0; k < QUAT_PARTS; k++) begin
			pm[k] = pm_s6[k];
		end
		for (int i = 0; i < 3; i++) begin
			t[i] = t_s6[i];
		end
	end

endmodule
`default_nettype wire

/* rtl/rtc_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module rtc_isqrt #(
	parameter int W   = 64,
	parameter int SBW = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [W-1:0]     x_in,
	input  logic [SBW-1:0]   side_in,
	output logic             out_vld,
	output logic [W/2-1:0]   root,
	output logic [SBW-1:0]   side_out
);
	localparam int NI = W / 2;

	logic [W-1:0]   x_s    [NI+1];
	logic [W-1:0]   r_s    [NI+1];
	logic           vld_s  [NI+1];
	logic [SBW-1:0] side_s [NI+1];

	assign x_s[0]    = x_in;
	assign r_s[0]    = '0;
	assign vld_s[0]  = in_vld;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < NI; k++) begin : g_stage
		localparam int SH = W - 2 - 2 * k;
		logic [W:0] trial;
		logic       ge;

		// Try the next root bit against the remaining radicand
		assign trial = {1'b0, r_s[k]} + ((W+1)'(1) << SH);
		assign ge    = {1'b0, x_s[k]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]    <= ge ? x_s[k] - trial[W-1:0] : x_s[k];
				r_s[k+1]    <= ge ? (r_s[k] >> 1) + (W'(1) << SH) : r_s[k] >> 1;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[NI];
	assign root     = r_s[NI][NI-1:0];
	assign side_out = side_s[NI];

endmodule
`default_nettype wire

/* rtl/rtc_div.sv */
// Pipelined rounding divider, four lanes sharing one divisor, one quotient bit per restoring stage.
`default_nettype none
module rtc_div #(
	parameter int F   = 30,
	parameter int SBW = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_vld,
	input  logic [F+1:0]                           n,
	input  logic [rtc_pkg::QUAT_PARTS-1:0][F+1:0]  mag,
	input  logic [SBW-1:0]                         side_in,
	output logic                                   out_vld,
	output logic [rtc_pkg::QUAT_PARTS-1:0][F:0]    quo,
	output logic [SBW-1:0]                         side_out
);
	import rtc_pkg::*;

	localparam int NS   = F + 2;
	localparam int NW   = F + 2;
	localparam int NUMW = 2 * F + 3;

	logic [NUMW-1:0] rem_s  [NS][QUAT_PARTS];
	logic [F:0]      q_s    [NS][QUAT_PARTS];
	logic [NW-1:0]   n_s    [NS];
	logic            vld_s  [NS];
	logic [SBW-1:0]  side_s [NS];

	// Prepare numerators with half the divisor added for rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else if (en)
			vld_s[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < QUAT_PARTS; l++) begin
				rem_s[0][l] <= (NUMW'(mag[l]) << F) + NUMW'(n >> 1);
				q_s[0][l]   <= '0;
			end
			n_s[0]    <= n;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k < NS; k++) begin : g_stage
		localparam int B = F + 1 - k;
		logic [NUMW-1:0] d;

		assign d = NUMW'(n_s[k-1]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= vld_s[k-1];
		end

		// Restoring step: subtract the shifted divisor where it fits
		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < QUAT_PARTS; l++) begin
					if (rem_s[k-1][l] >= d) begin
						rem_s[k][l] <= rem_s[k-1][l] - d;
						q_s[k][l]   <= q_s[k-1][l] | ((F+1)'(1) << B);
					end else begin
						rem_s[k][l] <= rem_s[k-1][l];
						q_s[k][l]   <= q_s[k-1][l];
					end
				end
				n_s[k]    <= n_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_vld  = vld_s[NS-1];
	assign side_out = side_s[NS-1];
	always_comb begin
		for (int l = 0; l < QUAT_PARTS; l++) begin
			quo[l] = q_s[NS-1][l];
		end
	end

endmodule
`default_nettype wire

/* rtl/rigid_transform_compose_top.sv */
// Top level of the rigid transform composer: configuration, pipeline and output register.
//
// Channel  | Direction | Handshake             | Payload
// s_*      | in        | s_tvalid / s_tready   | s_tdata: in_tx, in_ty, in_tz, in_qw..in_qz
// m_*      | out       | m_tvalid / m_tready   | m_tdata: out_tx..out_tz, out_qw..out_qz;
//          |           |                       | m_tuser: degenerate
// cfg_*    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One transaction is accepted every cycle while the output is not stalled; the pipeline
// includes the bit-serial square root and divider stages.
// arst_n clears all valid bits and loads the identity transform into the registers.
// A stalled output freezes every stage at once; cfg_ready is always high.
`default_nettype none
module rigid_transform_compose_top #(
	parameter int QUAT_FRAC_BITS = 30,
	parameter int TRANS_WIDTH    = 32
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           s_tvalid,
	output logic                                           s_tready,
	// in_tx, in_ty, in_tz, in_qw, in_qx, in_qy, in_qz (lowest first), zero pad
	input  logic [((3*TRANS_WIDTH+4*rtc_pkg::QUAT_W+7)/8)*8-1:0] s_tdata,
	output logic                                           m_tvalid,
	input  logic                                           m_tready,
	// out_tx, out_ty, out_tz, out_qw, out_qx, out_qy, out_qz (lowest first), zero pad
	output logic [((3*TRANS_WIDTH+4*rtc_pkg::QUAT_W+7)/8)*8-1:0] m_tdata,
	// degenerate
	output logic                                           m_tuser,
	input  logic                                           cfg_valid,
	output logic                                           cfg_ready,
	input  logic [rtc_pkg::CFG_IDX_W-1:0]                  cfg_index,
	input  logic [(TRANS_WIDTH > rtc_pkg::QUAT_W ? TRANS_WIDTH : rtc_pkg::QUAT_W)-1:0] cfg_data
);
	import rtc_pkg::*;

	localparam int F    = QUAT_FRAC_BITS;
	localparam int T    = TRANS_WIDTH;
	localparam int PMW  = F + 2;
	localparam int SW   = 2 * F + 4;
	localparam int DW   = 3 * T + 4 * QUAT_W;
	localparam int DWB  = ((DW + 7) / 8) * 8;
	localparam int SB1  = 3 * T + 1 + QUAT_PARTS + QUAT_PARTS * PMW;
	localparam int SB2  = 3 * T + 1 + QUAT_PARTS;
	localparam logic [QUAT_W-1:0] QONE = QUAT_W'(64'd1 << F);

	logic [2:0][T-1:0]                     base_t_q;
	logic [QUAT_PARTS-1:0][QUAT_W-1:0]     base_q_q;
	logic                                  en;
	logic [2:0][T-1:0]                     in_t;
	logic [QUAT_PARTS-1:0][QUAT_W-1:0]     in_q;
	logic                                  f_vld;
	logic [SW-1:0]                         f_sum;
	logic [QUAT_PARTS-1:0][PMW-1:0]        f_pm;
	logic [QUAT_PARTS-1:0]                 f_ps;
	logic                                  f_zero;
	logic [2:0][T-1:0]                     f_t;
	logic                                  r_vld;
	logic [PMW-1:0]                        r_root;
	logic [SB1-1:0]                        r_side;
	logic [QUAT_PARTS-1:0][PMW-1:0]        r_pm;
	logic [SB2-1:0]                        r_side2;
	logic                                  d_vld;
	logic [QUAT_PARTS-1:0][F:0]            d_quo;
	logic [SB2-1:0]                        d_side;
	logic [2:0][T-1:0]                     d_t;
	logic                                  d_zero;
	logic [QUAT_PARTS-1:0]                 d_ps;
	logic [QUAT_PARTS-1:0][QUAT_W-1:0]     o_q;
	logic                                  m_tvalid_q;
	logic [DW-1:0]                         m_data_q;
	logic                                  m_user_q;

	// Whole pipeline advances unless a finished result is held
	assign en        = !m_tvalid_q || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_t_q <= '0;
			base_q_q <= {{((QUAT_PARTS-1)*QUAT_W){1'b0}}, QONE};
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BASE_TX: base_t_q[0] <= cfg_data[T-1:0];
				REG_BASE_TY: base_t_q[1] <= cfg_data[T-1:0];
				REG_BASE_TZ: base_t_q[2] <= cfg_data[T-1:0];
				REG_BASE_QW: base_q_q[0] <= cfg_data[QUAT_W-1:0];
				REG_BASE_QX: base_q_q[1] <= cfg_data[QUAT_W-1:0];
				REG_BASE_QY: base_q_q[2] <= cfg_data[QUAT_W-1:0];
				REG_BASE_QZ: base_q_q[3] <= cfg_data[QUAT_W-1:0];
				default: ;
			endcase
		end
	end

	// Unpack the input transaction
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_t[i] = s_tdata[i*T +: T];
		end
		for (int k = 0; k < QUAT_PARTS; k++) begin
			in_q[k] = s_tdata[3*T + k*QUAT_W +: QUAT_W];
		end
	end

	rtc_front #(.F(F), .T(T)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_tvalid),
		.v       (in_t),
		.iq      (in_q),
		.bt      (base_t_q),
		.bq      (base_q_q),
		.out_vld (f_vld),
		.sum     (f_sum),
		.pm      (f_pm),
		.ps      (f_ps),
		.zero    (f_zero),
		.t       (f_t)
	);

	rtc_isqrt #(.W(SW), .SBW(SB1)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (f_vld),
		.x_in     (f_sum),
		.side_in  ({f_t, f_zero, f_ps, f_pm}),
		.out_vld  (r_vld),
		.root     (r_root),
		.side_out (r_side)
	);

	assign r_pm    = r_side[QUAT_PARTS*PMW-1:0];
	assign r_side2 = r_side[SB1-1:QUAT_PARTS*PMW];

	rtc_div #(.F(F), .SBW(SB2)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (r_vld),
		.n        (r_root),
		.mag      (r_pm),
		.side_in  (r_side2),
		.out_vld  (d_vld),
		.quo      (d_quo),
		.side_out (d_side)
	);

	assign d_ps   = d_side[QUAT_PARTS-1:0];
	assign d_zero = d_side[QUAT_PARTS];
	assign d_t    = d_side[SB2-1:QUAT_PARTS+1];

	// Clamp, apply sign, and substitute identity for a zero-norm product
	always_comb begin
		logic [QUAT_W-1:0] m;
		for (int k = 0; k < QUAT_PARTS; k++) begin
			m = QUAT_W'(d_quo[k]);
			if (m > QONE)
				m = QONE;
			if (d_zero)
				o_q[k] = (k == 0) ? QONE : '0;
			else
				o_q[k] = d_ps[k] ? -m : m;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (en)
			m_tvalid_q <= d_vld;
	end

	always_ff @(posedge clk) begin
		if (en && d_vld) begin
			m_data_q <= {o_q, d_t};
			m_user_q <= d_zero;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DWB'(m_data_q);
	assign m_tuser  = m_user_q;

	// Held result blocks new input in the same cycle
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while output stalled");

	// Degenerate result carries the identity rotation
	a_degenerate_identity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[3*T +: QUAT_W] == QONE)
			&& (m_tdata[3*T+QUAT_W +: 3*QUAT_W] == '0))
		else $error("degenerate result without identity rotation");

	// Normalized scalar part stays within unit range
	a_scalar_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> ($signed(m_tdata[3*T +: QUAT_W]) <= $signed(QONE))
			&& ($signed(m_tdata[3*T +: QUAT_W]) >= -$signed(QONE)))
		else $error("normalized scalar part out of range");

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the rigid transform composer: random poses, several held transforms.
`timescale 1ns / 100ps
module testbench;
	import rtc_pkg::*;

	localparam int QF        = 30;
	localparam int TW        = 32;
	localparam int DW        = 3*TW + 4*QUAT_W;
	localparam int DRAIN     = 2*QF + 20;
	localparam int IDLE_LIMIT = 8000;
	localparam logic signed [63:0] Q_ONE = 64'sd1 <<< QF;

	// members listed from the highest bits down, so tx sits in the lowest word
	typedef struct packed {
		logic [31:0] qz, qy, qx, qw, tz, ty, tx;
	} pose_t;

	typedef struct packed {
		logic [31:0] qz, qy, qx, qw, tz, ty, tx;
		logic        degenerate;
	} composed_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [DW-1:0] s_tdata = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [DW-1:0] m_tdata;
	logic          m_tuser;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]   cfg_data = '0;

	pose_t     pose_q[$];
	composed_t composed_q[$];
	logic [31:0] held[7];
	bit        failed = 0;

	rigid_transform_compose_top dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------- fixed-point helpers ----------------
	function automatic logic signed [63:0] clamp_part(logic [31:0] raw);
		logic signed [63:0] v;
		v = 64'(signed'(raw));
		if (v > Q_ONE) v = Q_ONE;
		if (v < -Q_ONE) v = -Q_ONE;
		return v;
	endfunction

	// round(a*b / 2^sh) half away from zero, magnitude limited to 2^62
	function automatic logic signed [63:0] mul_round(logic signed [63:0] a,
			logic signed [63:0] b, int sh);
		logic signed [127:0] p;
		logic [127:0] m;
		p = 128'(a) * 128'(b);
		m = p < 0 ? -p : p;
		m = (m + (128'd1 << (sh - 1))) >> sh;
		if (m > (128'd1 << 62)) m = 128'd1 << 62;
		return p < 0 ? -64'(m) : 64'(m);
	endfunction

	function automatic logic signed [63:0] shift_round(logic signed [63:0] v, int sh);
		logic [63:0] m;
		m = v < 0 ? -v : v;
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return v < 0 ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [31:0] sat_trans(logic signed [63:0] v);
		if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
		if (v < -64'sh80000000) v = -64'sh80000000;
		return v[31:0];
	endfunction

	// Compose the held transform onto one input pose
	function automatic composed_t compose_pose(pose_t p);
		composed_t r;
		logic signed [63:0] aw, ax, ay, az, bw, bx, by, bz, vx, vy, vz;
		logic signed [63:0] cx, cy, cz, rx, ry, rz;
		logic signed [63:0] h[4];
		logic [63:0] sum, n, m;
		aw = clamp_part(held[REG_BASE_QW]); ax = clamp_part(held[REG_BASE_QX]);
		ay = clamp_part(held[REG_BASE_QY]); az = clamp_part(held[REG_BASE_QZ]);
		bw = clamp_part(p.qw); bx = clamp_part(p.qx);
		by = clamp_part(p.qy); bz = clamp_part(p.qz);
		vx = 64'(signed'(p.tx)); vy = 64'(signed'(p.ty)); vz = 64'(signed'(p.tz));
		// rotate translation by held quaternion, then offset
		cx = 2 * (mul_round(ay, vz, QF) - mul_round(az, vy, QF));
		cy = 2 * (mul_round(az, vx, QF) - mul_round(ax, vz, QF));
		cz = 2 * (mul_round(ax, vy, QF) - mul_round(ay, vx, QF));
		rx = vx + mul_round(aw, cx, QF) + mul_round(ay, cz, QF) - mul_round(az, cy, QF);
		ry = vy + mul_round(aw, cy, QF) + mul_round(az, cx, QF) - mul_round(ax, cz, QF);
		rz = vz + mul_round(aw, cz, QF) + mul_round(ax, cy, QF) - mul_round(ay, cx, QF);
		r.tx = sat_trans(rx + 64'(signed'(held[REG_BASE_TX])));
		r.ty = sat_trans(ry + 64'(signed'(held[REG_BASE_TY])));
		r.tz = sat_trans(rz + 64'(signed'(held[REG_BASE_TZ])));
		// Hamilton product at one fraction bit less
		h[0] = shift_round(aw*bw - ax*bx - ay*by - az*bz, QF + 1);
		h[1] = shift_round(aw*bx + ax*bw + ay*bz - az*by, QF + 1);
		h[2] = shift_round(aw*by - ax*bz + ay*bw + az*bx, QF + 1);
		h[3] = shift_round(aw*bz + ax*by - ay*bx + az*bw, QF + 1);
		sum = 0;
		for (int i = 0; i < 4; i++) begin
			m = h[i] < 0 ? -h[i] : h[i];
			sum = sum + m * m;
		end
		if (sum == 0) begin
			r.qw = Q_ONE[31:0]; r.qx = '0; r.qy = '0; r.qz = '0;
			r.degenerate = 1'b1;
			return r;
		end
		n = int_sqrt(sum);
		for (int i = 0; i < 4; i++) begin
			m = h[i] < 0 ? -h[i] : h[i];
			m = ((m << QF) + (n >> 1)) / n;
			if (m > 64'(Q_ONE)) m = 64'(Q_ONE);
			h[i] = h[i] < 0 ? -$signed(m) : $signed(m);
		end
		r.qw = h[0][31:0]; r.qx = h[1][31:0]; r.qy = h[2][31:0]; r.qz = h[3][31:0];
		r.degenerate = 1'b0;
		return r;
	endfunction

	// ---------------- stimulus values ----------------
	function automatic logic [31:0] rand_part();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
			5: return $urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000;
			6: return '0;
			7: return $urandom();
			8: return 32'($signed($urandom_range(0, 64)) - 32);
			default: return 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_trans();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: return 32'($signed($urandom_range(0, 2000)) - 1000);
			2: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic pose_t rand_pose();
		pose_t p;
		p.tx = rand_trans(); p.ty = rand_trans(); p.tz = rand_trans();
		p.qw = rand_part(); p.qx = rand_part(); p.qy = rand_part(); p.qz = rand_part();
		if ($urandom_range(0, 19) == 0) begin
			p.qw = '0; p.qx = '0; p.qy = '0; p.qz = '0;
		end
		return p;
	endfunction

	// ---------------- driver ----------------
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		pose_t p;
		logic nxt_valid;
		logic [DW-1:0] nxt_data;
		nxt_valid = s_tvalid;
		nxt_data = s_tdata;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				composed_q.push_back(compose_pose(s_tdata));
				nxt_valid = 1'b0;
			end
			// hold a transaction that has not been taken
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pose_q.size() > 0) begin
					p = pose_q.pop_front();
					nxt_valid = 1'b1;
					nxt_data = p;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
		s_tvalid <= nxt_valid;
		s_tdata <= nxt_data;
	end

	// ---------------- receiver stall pattern ----------------
	int cyc = 0;
	always @(posedge clk) begin
		logic rdy;
		cyc++;
		case ((cyc / 300) % 4)
			0: rdy = 1'b1;
			1: rdy = $urandom_range(0, 1);
			2: rdy = (cyc % 5) != 0;
			default: rdy = $urandom_range(0, 7) == 0;
		endcase
		m_tready <= rdy;
	end

	// ---------------- held transform copy ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (held[i]) held[i] = '0;
			held[REG_BASE_QW] = Q_ONE[31:0];
		end else if (cfg_valid && cfg_ready && cfg_index <= REG_BASE_QZ) begin
			held[cfg_index] = cfg_data;
		end
	end

	// ---------------- monitor and watchdog ----------------
	int idle_cycles = 0;
	always @(posedge clk) begin
		composed_t got, want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (m_tvalid && m_tready) begin
				got = {m_tdata, m_tuser};
				if (composed_q.size() == 0) begin
					$display("%0t: unexpected transaction, actual %h", $time, got);
					failed = 1;
				end else begin
					want = composed_q.pop_front();
					if (got.tx !== want.tx) begin
						$display("%0t: out_tx expected %h actual %h", $time, want.tx, got.tx);
						failed = 1;
					end
					if (got.ty !== want.ty) begin
						$display("%0t: out_ty expected %h actual %h", $time, want.ty, got.ty);
						failed = 1;
					end
					if (got.tz !== want.tz) begin
						$display("%0t: out_tz expected %h actual %h", $time, want.tz, got.tz);
						failed = 1;
					end
					if (got.qw !== want.qw) begin
						$display("%0t: out_qw expected %h actual %h", $time, want.qw, got.qw);
						failed = 1;
					end
					if (got.qx !== want.qx) begin
						$display("%0t: out_qx expected %h actual %h", $time, want.qx, got.qx);
						failed = 1;
					end
					if (got.qy !== want.qy) begin
						$display("%0t: out_qy expected %h actual %h", $time, want.qy, got.qy);
						failed = 1;
					end
					if (got.qz !== want.qz) begin
						$display("%0t: out_qz expected %h actual %h", $time, want.qz, got.qz);
						failed = 1;
					end
					if (got.degenerate !== want.degenerate) begin
						$display("%0t: degenerate expected %b actual %b", $time,
							want.degenerate, got.degenerate);
						failed = 1;
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[rigid_transform_compose_top] ERROR");
				$finish;
			end
		end
	end

	// ---------------- sequencing ----------------
	task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_base(logic [31:0] tx, ty, tz, qw, qx, qy, qz);
		write_reg(REG_BASE_TX, tx); write_reg(REG_BASE_TY, ty);
		write_reg(REG_BASE_TZ, tz); write_reg(REG_BASE_QW, qw);
		write_reg(REG_BASE_QX, qx); write_reg(REG_BASE_QY, qy);
		write_reg(REG_BASE_QZ, qz);
	endtask

	task automatic drain();
		do @(posedge clk); while (pose_q.size() != 0 || s_tvalid || composed_q.size() != 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic push_pose(logic [31:0] tx, ty, tz, qw, qx, qy, qz);
		pose_t p;
		p.tx = tx; p.ty = ty; p.tz = tz;
		p.qw = qw; p.qx = qx; p.qy = qy; p.qz = qz;
		pose_q.push_back(p);
	endtask

	task automatic push_random(int count);
		repeat (count) pose_q.push_back(rand_pose());
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: identity, zero quaternion, extremes, out-of-range parts
		push_pose(0, 0, 0, 32'h4000_0000, 0, 0, 0);
		push_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0, 0, 0, 0);
		push_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hC000_0000, 0, 0, 0);
		push_pose(1, 2, 3, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000);
		push_pose(0, 0, 0, 32'hC000_0000, 32'hC000_0000, 32'hC000_0000, 32'hC000_0000);
		push_pose(5, 5, 5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		push_pose(0, 0, 0, 1, 0, 0, 0);
		push_pose(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
		push_pose(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_pose(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'h2D41_3CCD, 32'h2D41_3CCD, 0, 0);
		push_random(400);
		drain();

		// rotation about z by 90 deg with large offset: drives translation saturation
		set_base(32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000,
			32'h2D41_3CCD, 0, 0, 32'h2D41_3CCD);
		push_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h4000_0000, 0, 0, 0);
		push_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h2D41_3CCD, 0, 0,
			32'hD2BE_C333);
		push_random(400);
		drain();

		// negative full-scale, non-unit base quaternion
		set_base(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'hC000_0000, 32'hC000_0000, 32'hC000_0000, 32'hC000_0000);
		push_random(350);
		drain();

		// out-of-range register values get clamped
		set_base(32'h0001_0000, 32'hFFFF_0000, 0,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'hEDCB_A988);
		push_random(350);
		drain();

		// zero base quaternion: every product is degenerate
		set_base($urandom(), $urandom(), $urandom(), 0, 0, 0, 0);
		push_random(150);
		drain();

		// random base
		set_base(rand_trans(), rand_trans(), rand_trans(),
			rand_part(), rand_part(), rand_part(), rand_part());
		push_random(300);
		drain();

		if (!failed) begin
			$display("[rigid_transform_compose_top] OK");
		end else begin
			$display("[rigid_transform_compose_top] ERROR");
		end
		$finish;
	end

endmodule
